FILE: rtl/mhdf_pkg.sv
package mhdf_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NORMAL_WIDTH    = 18;
   localparam int NUM_SLOTS       = 14;
   localparam int SLOT_W          = 4;
   localparam int ADDR_W          = 5;
   localparam int RAM_DEPTH       = 32;
   localparam int COMP_W          = 3;
   localparam int CSR_IDX_W       = 2;
   localparam int PROG_LEN        = 70;
   localparam int PC_W            = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_MODE = 2'd3;

   // flux component codes
   localparam logic [COMP_W-1:0] C_MASS   = 3'd0;
   localparam logic [COMP_W-1:0] C_ENERGY = 3'd1;
   localparam logic [COMP_W-1:0] C_MOM_X  = 3'd2;
   localparam logic [COMP_W-1:0] C_MOM_Y  = 3'd3;
   localparam logic [COMP_W-1:0] C_MOM_Z  = 3'd4;
   localparam logic [COMP_W-1:0] C_FLD_X  = 3'd5;
   localparam logic [COMP_W-1:0] C_FLD_Y  = 3'd6;
   localparam logic [COMP_W-1:0] C_FLD_Z  = 3'd7;

   // memory map: cell slots, then scratch
   localparam logic [ADDR_W-1:0] A_U0  = 5'd0;
   localparam logic [ADDR_W-1:0] A_U1  = 5'd1;
   localparam logic [ADDR_W-1:0] A_U2  = 5'd2;
   localparam logic [ADDR_W-1:0] A_U3  = 5'd3;
   localparam logic [ADDR_W-1:0] A_B0  = 5'd4;
   localparam logic [ADDR_W-1:0] A_B1  = 5'd5;
   localparam logic [ADDR_W-1:0] A_B2  = 5'd6;
   localparam logic [ADDR_W-1:0] A_B3  = 5'd7;
   localparam logic [ADDR_W-1:0] A_S0  = 5'd8;
   localparam logic [ADDR_W-1:0] A_S1  = 5'd9;
   localparam logic [ADDR_W-1:0] A_S2  = 5'd10;
   localparam logic [ADDR_W-1:0] A_S3  = 5'd11;
   localparam logic [ADDR_W-1:0] A_RHO = 5'd12;
   localparam logic [ADDR_W-1:0] A_P   = 5'd13;
   localparam logic [ADDR_W-1:0] A_DD  = 5'd14;
   localparam logic [ADDR_W-1:0] A_TAU = 5'd15;
   localparam logic [ADDR_W-1:0] A_V1  = 5'd16;
   localparam logic [ADDR_W-1:0] A_V2  = 5'd17;
   localparam logic [ADDR_W-1:0] A_V3  = 5'd18;
   localparam logic [ADDR_W-1:0] A_F1  = 5'd19;
   localparam logic [ADDR_W-1:0] A_F2  = 5'd20;
   localparam logic [ADDR_W-1:0] A_F3  = 5'd21;
   localparam logic [ADDR_W-1:0] A_BN  = 5'd22;
   localparam logic [ADDR_W-1:0] A_VN  = 5'd23;
   localparam logic [ADDR_W-1:0] A_N1  = 5'd24;
   localparam logic [ADDR_W-1:0] A_N2  = 5'd25;
   localparam logic [ADDR_W-1:0] A_N3  = 5'd26;
   localparam logic [ADDR_W-1:0] A_TX  = 5'd27;
   localparam logic [ADDR_W-1:0] A_TY  = 5'd28;

   typedef enum logic [2:0] {
      OP_LDN  = 3'd0,
      OP_MUL  = 3'd1,
      OP_DIV  = 3'd2,
      OP_ADD  = 3'd3,
      OP_SUB  = 3'd4,
      OP_SUBR = 3'd5,
      OP_EMIT = 3'd6
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   a;
      logic [ADDR_W-1:0]   b;
      logic [ADDR_W-1:0]   d;
      logic [COMP_W-1:0]   comp;
   } ucode_type;

   function automatic ucode_type uc(input op_type op, input logic [ADDR_W-1:0] a,
                                    input logic [ADDR_W-1:0] b,
                                    input logic [ADDR_W-1:0] d,
                                    input logic [COMP_W-1:0] comp);
      ucode_type r;
      r.op   = op;
      r.a    = a;
      r.b    = b;
      r.d    = d;
      r.comp = comp;
      return r;
   endfunction

   // flux program; LDN takes the normal index in its a field, DIV divides a by gamma
   function automatic ucode_type ucode_at(input logic [PC_W-1:0] pc);
      ucode_type r;
      case (pc)
         7'd0:  r = uc(OP_LDN,  5'd0,  A_U0, A_N1, C_MASS);
         7'd1:  r = uc(OP_LDN,  5'd1,  A_U0, A_N2, C_MASS);
         7'd2:  r = uc(OP_LDN,  5'd2,  A_U0, A_N3, C_MASS);
         7'd3:  r = uc(OP_MUL,  A_RHO, A_U0, A_DD, C_MASS);
         7'd4:  r = uc(OP_ADD,  A_DD,  A_P,  A_TX, C_MASS);
         7'd5:  r = uc(OP_SUB,  A_S0,  A_TX, A_TAU, C_MASS);
         7'd6:  r = uc(OP_DIV,  A_U1,  A_U0, A_V1, C_MASS);
         7'd7:  r = uc(OP_MUL,  A_B1,  A_U0, A_F1, C_MASS);
         7'd8:  r = uc(OP_MUL,  A_B0,  A_U1, A_TX, C_MASS);
         7'd9:  r = uc(OP_SUBR, A_F1,  A_TX, A_F1, C_MASS);
         7'd10: r = uc(OP_DIV,  A_U2,  A_U0, A_V2, C_MASS);
         7'd11: r = uc(OP_MUL,  A_B2,  A_U0, A_F2, C_MASS);
         7'd12: r = uc(OP_MUL,  A_B0,  A_U2, A_TX, C_MASS);
         7'd13: r = uc(OP_SUBR, A_F2,  A_TX, A_F2, C_MASS);
         7'd14: r = uc(OP_DIV,  A_U3,  A_U0, A_V3, C_MASS);
         7'd15: r = uc(OP_MUL,  A_B3,  A_U0, A_F3, C_MASS);
         7'd16: r = uc(OP_MUL,  A_B0,  A_U3, A_TX, C_MASS);
         7'd17: r = uc(OP_SUBR, A_F3,  A_TX, A_F3, C_MASS);
         7'd18: r = uc(OP_MUL,  A_F1,  A_N1, A_BN, C_MASS);
         7'd19: r = uc(OP_MUL,  A_V1,  A_N1, A_VN, C_MASS);
         7'd20: r = uc(OP_MUL,  A_F2,  A_N2, A_TX, C_MASS);
         7'd21: r = uc(OP_ADD,  A_BN,  A_TX, A_BN, C_MASS);
         7'd22: r = uc(OP_MUL,  A_V2,  A_N2, A_TX, C_MASS);
         7'd23: r = uc(OP_ADD,  A_VN,  A_TX, A_VN, C_MASS);
         7'd24: r = uc(OP_MUL,  A_F3,  A_N3, A_TX, C_MASS);
         7'd25: r = uc(OP_ADD,  A_BN,  A_TX, A_BN, C_MASS);
         7'd26: r = uc(OP_MUL,  A_V3,  A_N3, A_TX, C_MASS);
         7'd27: r = uc(OP_ADD,  A_VN,  A_TX, A_VN, C_MASS);
         7'd28: r = uc(OP_MUL,  A_DD,  A_VN, A_TX, C_MASS);
         7'd29: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_MASS);
         7'd30: r = uc(OP_MUL,  A_TAU, A_VN, A_TX, C_ENERGY);
         7'd31: r = uc(OP_MUL,  A_P,   A_VN, A_TY, C_ENERGY);
         7'd32: r = uc(OP_ADD,  A_TX,  A_TY, A_TX, C_ENERGY);
         7'd33: r = uc(OP_MUL,  A_B0,  A_BN, A_TY, C_ENERGY);
         7'd34: r = uc(OP_DIV,  A_TY,  A_U0, A_TY, C_ENERGY);
         7'd35: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_ENERGY);
         7'd36: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_ENERGY);
         7'd37: r = uc(OP_MUL,  A_S1,  A_VN, A_TX, C_MOM_X);
         7'd38: r = uc(OP_MUL,  A_P,   A_N1, A_TY, C_MOM_X);
         7'd39: r = uc(OP_ADD,  A_TX,  A_TY, A_TX, C_MOM_X);
         7'd40: r = uc(OP_MUL,  A_B1,  A_BN, A_TY, C_MOM_X);
         7'd41: r = uc(OP_DIV,  A_TY,  A_U0, A_TY, C_MOM_X);
         7'd42: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_MOM_X);
         7'd43: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_MOM_X);
         7'd44: r = uc(OP_MUL,  A_S2,  A_VN, A_TX, C_MOM_Y);
         7'd45: r = uc(OP_MUL,  A_P,   A_N2, A_TY, C_MOM_Y);
         7'd46: r = uc(OP_ADD,  A_TX,  A_TY, A_TX, C_MOM_Y);
         7'd47: r = uc(OP_MUL,  A_B2,  A_BN, A_TY, C_MOM_Y);
         7'd48: r = uc(OP_DIV,  A_TY,  A_U0, A_TY, C_MOM_Y);
         7'd49: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_MOM_Y);
         7'd50: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_MOM_Y);
         7'd51: r = uc(OP_MUL,  A_S3,  A_VN, A_TX, C_MOM_Z);
         7'd52: r = uc(OP_MUL,  A_P,   A_N3, A_TY, C_MOM_Z);
         7'd53: r = uc(OP_ADD,  A_TX,  A_TY, A_TX, C_MOM_Z);
         7'd54: r = uc(OP_MUL,  A_B3,  A_BN, A_TY, C_MOM_Z);
         7'd55: r = uc(OP_DIV,  A_TY,  A_U0, A_TY, C_MOM_Z);
         7'd56: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_MOM_Z);
         7'd57: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_MOM_Z);
         7'd58: r = uc(OP_MUL,  A_F1,  A_VN, A_TX, C_FLD_X);
         7'd59: r = uc(OP_MUL,  A_BN,  A_V1, A_TY, C_FLD_X);
         7'd60: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_FLD_X);
         7'd61: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_FLD_X);
         7'd62: r = uc(OP_MUL,  A_F2,  A_VN, A_TX, C_FLD_Y);
         7'd63: r = uc(OP_MUL,  A_BN,  A_V2, A_TY, C_FLD_Y);
         7'd64: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_FLD_Y);
         7'd65: r = uc(OP_EMIT, A_TX,  A_TX, A_TX, C_FLD_Y);
         7'd66: r = uc(OP_MUL,  A_F3,  A_VN, A_TX, C_FLD_Z);
         7'd67: r = uc(OP_MUL,  A_BN,  A_V3, A_TY, C_FLD_Z);
         7'd68: r = uc(OP_SUB,  A_TX,  A_TY, A_TX, C_FLD_Z);
         default: r = uc(OP_EMIT, A_TX, A_TX, A_TX, C_FLD_Z);
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/mhdf_ram.sv
module mhdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/mhdf_mul.sv
module mhdf_mul
   import mhdf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] a,
   input  logic [VALUE_WIDTH-1:0] b,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] res
);

   localparam int W     = VALUE_WIDTH;
   localparam int H     = (W + 1) / 2;
   localparam int MW    = 2 * H;
   localparam int ACC_W = 4 * H;

   logic [MW-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [1:0]       step_ff, step_in;
   logic             run_ff, run_in, sat_ff, sat_in, done_ff, done_in;
   logic [W-1:0]     res_ff, res_in;
   logic [H-1:0]     ach, bch;
   logic [MW-1:0]    pp;
   logic [ACC_W-1:0] pp_sh, q;
   logic             ovf;
   logic [W-1:0]     mag_a, mag_b, vmax;

   assign mag_a = a[W-1] ? (~a + W'(1)) : a;
   assign mag_b = b[W-1] ? (~b + W'(1)) : b;
   assign vmax  = {1'b0, {(W-1){1'b1}}};

   // one half-width partial product a step
   assign ach = step_ff[1] ? ma_ff[MW-1:H] : ma_ff[H-1:0];
   assign bch = step_ff[0] ? mb_ff[MW-1:H] : mb_ff[H-1:0];
   assign pp  = MW'(ach) * MW'(bch);

   always_comb begin
      case ({1'b0, step_ff[1]} + {1'b0, step_ff[0]})
         2'd0:    pp_sh = ACC_W'(pp);
         2'd1:    pp_sh = ACC_W'(pp) << H;
         default: pp_sh = ACC_W'(pp) << (2 * H);
      endcase
   end

   assign q   = acc_ff >> FRAC_BITS;
   assign ovf = |q[ACC_W-1:W-1];

   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      run_in  = run_ff;
      sat_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         ma_in   = MW'(mag_a);
         mb_in   = MW'(mag_b);
         neg_in  = a[W-1] ^ b[W-1];
         acc_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
            sat_in = 1'b1;
         end
      end else if (sat_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            res_in = ovf ? ~vmax : (~q[W-1:0] + W'(1));
         end else begin
            res_in = ovf ? vmax : q[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         sat_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         sat_ff  <= sat_in;
         done_ff <= done_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

FILE: rtl/mhdf_div.sv
module mhdf_div
   import mhdf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] x,
   input  logic [VALUE_WIDTH-1:0] gamma,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] res
);

   localparam int W  = VALUE_WIDTH;
   localparam int NW = VALUE_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [W-1:0]  d_ff, d_in, r_ff, r_in, res_ff, res_in;
   logic [NW-1:0] num_ff, num_in, q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in, run_ff, run_in, sat_ff, sat_in, done_ff, done_in;
   logic [W:0]    r2;
   logic          ge, ovf;
   logic [W-1:0]  one, mag_x, vmax;

   assign one   = W'(1) << FRAC_BITS;
   assign mag_x = x[W-1] ? (~x + W'(1)) : x;
   assign vmax  = {1'b0, {(W-1){1'b1}}};

   // restoring division, one quotient bit a cycle
   assign r2  = {r_ff, num_ff[NW-1]};
   assign ge  = r2 >= {1'b0, d_ff};
   assign ovf = |q_ff[NW-1:W-1];

   always_comb begin
      d_in    = d_ff;
      r_in    = r_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      sat_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         // gamma below one divides by one
         d_in   = ($signed(gamma) > $signed(one)) ? gamma : one;
         r_in   = '0;
         num_in = NW'(mag_x) << FRAC_BITS;
         q_in   = '0;
         cnt_in = '0;
         neg_in = x[W-1];
         run_in = 1'b1;
      end else if (run_ff) begin
         r_in   = ge ? W'(r2 - {1'b0, d_ff}) : r2[W-1:0];
         q_in   = {q_ff[NW-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            run_in = 1'b0;
            sat_in = 1'b1;
         end
      end else if (sat_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            res_in = ovf ? ~vmax : (~q_ff[W-1:0] + W'(1));
         end else begin
            res_in = ovf ? vmax : q_ff[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         sat_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         sat_ff  <= sat_in;
         done_ff <= done_in;
      end
      d_ff   <= d_in;
      r_ff   <= r_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

FILE: rtl/mhd_face_flux.sv
// Ideal MHD face flux for one cell, signed fixed point with saturation.
// Input: a word is taken on a clock edge with start high and busy low; it
// stores req_value in cell slot req_slot (slots 14 and 15 are dropped).
// A word without req_last leaves busy low.
// A word with req_last raises busy while a 70-step program runs from the
// quantity memory through one shared multiplier and one shared divider.
// Each step passes through the issue, fetch, execute and write-back states;
// multiplies form four partial products, divides make one quotient bit a
// cycle; a run holds 7 divides and 32 multiplies, and all steps share the
// single read/modify/write path through the memory.
// Results: eight words on rsp_*, each valid for one cycle with rsp_strobe,
// in order mass, energy, momentum xyz, field xyz; rsp_final_res marks the
// last. The receiver cannot stall: every strobe is a delivered word.
// Configuration: csr_we writes the normal components or the mode at once;
// write only while busy is low.
// Reset: normal (1,0,0), relativistic mode on, all slots read as zero
// until written; loaded values persist across runs.
module mhd_face_flux
   import mhdf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [SLOT_W-1:0]       req_slot,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   input  logic                    req_last,
   output logic                    rsp_strobe,
   output logic [COMP_W-1:0]       rsp_component,
   output logic [VALUE_WIDTH-1:0]  rsp_flux_value,
   output logic                    rsp_final_res,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [NORMAL_WIDTH-1:0] csr_wdata
);

   localparam int W    = VALUE_WIDTH;
   localparam int NX_W = (W > NORMAL_WIDTH) ? W : NORMAL_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_WB    = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NORMAL_WIDTH-1:0] nx_ff, ny_ff, nz_ff;
   logic                 mode_ff;
   logic [W-1:0]         opa_ff, opa_in, opb_ff, opb_in, res_ff, res_in;
   logic                 strobe_ff, strobe_in;
   logic [COMP_W-1:0]    comp_ff, comp_in;
   logic [W-1:0]         flux_ff, flux_in;

   ucode_type            cur;
   logic                 accept;
   logic                 we;
   logic [ADDR_W-1:0]    waddr;
   logic [W-1:0]         wdata, rd_a, rd_b, opa_c, opb_c;
   logic                 mul_start, mul_done, div_start, div_done;
   logic [W-1:0]         mul_res, div_res;
   logic [W:0]           sum_w, dif_w;
   logic [W-1:0]         sum_s, dif_s, vmax, ldn_v;
   logic [NORMAL_WIDTH-1:0] nsel;

   assign cur    = ucode_at(pc_ff);
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign vmax   = {1'b0, {(W-1){1'b1}}};

   // memory write: loads while idle, results at write-back
   always_comb begin
      we    = 1'b0;
      waddr = {1'b0, req_slot};
      wdata = req_value;
      if (accept) begin
         we = (req_slot < SLOT_W'(NUM_SLOTS));
      end else if (state_ff == ST_WB && cur.op != OP_EMIT) begin
         we    = 1'b1;
         waddr = cur.d;
         wdata = res_ff;
      end
   end

   // two copies give two read ports
   mhdf_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram_a (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(cur.a), .rdata(rd_a)
   );

   mhdf_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram_b (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(cur.b), .rdata(rd_b)
   );

   // unwritten cell slots read as zero
   assign opa_c = (cur.a < ADDR_W'(NUM_SLOTS) && !valid_ff[cur.a[SLOT_W-1:0]]) ? '0 : rd_a;
   assign opb_c = (cur.b < ADDR_W'(NUM_SLOTS) && !valid_ff[cur.b[SLOT_W-1:0]]) ? '0 : rd_b;

   assign mul_start = (state_ff == ST_FETCH) && (cur.op == OP_MUL);
   assign div_start = (state_ff == ST_FETCH) && (cur.op == OP_DIV);

   mhdf_mul #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(opa_c), .b(opb_c),
      .done(mul_done), .res(mul_res)
   );

   mhdf_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .x(opa_c), .gamma(opb_c),
      .done(div_done), .res(div_res)
   );

   // saturating add and subtract
   assign sum_w = {opa_ff[W-1], opa_ff} + {opb_ff[W-1], opb_ff};
   assign dif_w = {opa_ff[W-1], opa_ff} - {opb_ff[W-1], opb_ff};
   assign sum_s = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? ~vmax : vmax) : sum_w[W-1:0];
   assign dif_s = (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? ~vmax : vmax) : dif_w[W-1:0];

   always_comb begin
      case (cur.a[1:0])
         2'd0:    nsel = nx_ff;
         2'd1:    nsel = ny_ff;
         default: nsel = nz_ff;
      endcase
   end

   assign ldn_v = W'(NX_W'($signed(nsel)));

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      valid_in  = valid_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      res_in    = res_ff;
      strobe_in = 1'b0;
      comp_in   = comp_ff;
      flux_in   = flux_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_slot < SLOT_W'(NUM_SLOTS)) begin
                  valid_in[req_slot] = 1'b1;
               end
               if (req_last) begin
                  pc_in    = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            opa_in   = opa_c;
            opb_in   = opb_c;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (cur.op)
               OP_MUL: begin
                  if (mul_done) begin
                     res_in   = mul_res;
                     state_in = ST_WB;
                  end
               end
               OP_DIV: begin
                  if (div_done) begin
                     res_in   = div_res;
                     state_in = ST_WB;
                  end
               end
               OP_ADD: begin
                  res_in   = sum_s;
                  state_in = ST_WB;
               end
               OP_SUB: begin
                  res_in   = dif_s;
                  state_in = ST_WB;
               end
               OP_SUBR: begin
                  res_in   = mode_ff ? dif_s : opa_ff;
                  state_in = ST_WB;
               end
               OP_LDN: begin
                  res_in   = ldn_v;
                  state_in = ST_WB;
               end
               OP_EMIT: begin
                  strobe_in = 1'b1;
                  comp_in   = cur.comp;
                  flux_in   = opa_ff;
                  state_in  = ST_WB;
               end
               default: begin
                  state_in = ST_WB;
               end
            endcase
         end
         ST_WB: begin
            pc_in    = pc_ff + PC_W'(1);
            state_in = (pc_ff == PC_W'(PROG_LEN - 1)) ? ST_IDLE : ST_ISSUE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
         nx_ff     <= NORMAL_WIDTH'(1) << FRAC_BITS;
         ny_ff     <= '0;
         nz_ff     <= '0;
         mode_ff   <= 1'b1;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NORMAL_X: nx_ff   <= csr_wdata;
               CSR_NORMAL_Y: ny_ff   <= csr_wdata;
               CSR_NORMAL_Z: nz_ff   <= csr_wdata;
               CSR_REL_MODE: mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      res_ff  <= res_in;
      comp_ff <= comp_in;
      flux_ff <= flux_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_component  = comp_ff;
   assign rsp_flux_value = flux_ff;
   assign rsp_final_res  = (comp_ff == C_FLD_Z);

`ifndef SYNTHESIS
   a_strobe_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result word outside a run");
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last |=> !busy) else $error("plain load started a run");
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy) else $error("last word did not start a run");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_final_res |=> !busy) else $error("run did not end after final word");
`endif

endmodule
